// ----- rtl/fda_pkg.sv -----
package fda_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned INT_W      = 15;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned CFG_W      = 3;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  // A 15-bit integer part has at most five decimal digits.
  localparam int unsigned INT_DIGITS = 5;
  localparam int unsigned ICNT_W     = 3;

  // Division by ten through a reciprocal: q = (x * 52429) >> 19 is exact
  // for every x below 81920, which covers the whole integer range.
  localparam int unsigned        RECIP_W     = 16;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN   = 16'd52429;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  localparam logic [CFG_W-1:0] FRAC_DIGITS_RST = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic pop_int;
    logic emit_point;
    logic emit_frac;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_zero;
    logic icnt_one;
    logic fcnt_one;
    logic k_zero;
    logic slot_free;
  } sts_t;

endpackage

// ----- rtl/fda_ctrl.sv -----
module fda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fda_pkg::sts_t sts_i,
  output fda_pkg::cmd_t cmd_o
);

  fda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fda_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fda_pkg::ST_CONV;
        end
      end
      fda_pkg::ST_CONV: begin
        if (sts_i.q_zero) begin
          state_d = fda_pkg::ST_INT;
        end
      end
      fda_pkg::ST_INT: begin
        if (sts_i.slot_free && sts_i.icnt_one) begin
          state_d = sts_i.k_zero ? fda_pkg::ST_IDLE : fda_pkg::ST_POINT;
        end
      end
      fda_pkg::ST_POINT: begin
        if (sts_i.slot_free) begin
          state_d = fda_pkg::ST_FRAC;
        end
      end
      fda_pkg::ST_FRAC: begin
        if (sts_i.slot_free && sts_i.fcnt_one) begin
          state_d = fda_pkg::ST_IDLE;
        end
      end
      default: state_d = fda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fda_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      fda_pkg::ST_CONV:  cmd_o.conv       = 1'b1;
      fda_pkg::ST_INT:   cmd_o.pop_int    = sts_i.slot_free;
      fda_pkg::ST_POINT: cmd_o.emit_point = sts_i.slot_free;
      fda_pkg::ST_FRAC:  cmd_o.emit_frac  = sts_i.slot_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A character is only handed to the output register when it has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop_int || cmd_o.emit_point || cmd_o.emit_frac) |-> sts_i.slot_free)
    else $error("character emitted while output register is full");

  // The point is always followed by at least one fraction digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_point |=> (state_q == fda_pkg::ST_FRAC))
    else $error("point not followed by fraction digits");

endmodule

// ----- rtl/fda_dp.sv -----
module fda_dp #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned MAX_FRAC_DIGITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fda_pkg::cmd_t                 cmd_i,
  output fda_pkg::sts_t                 sts_o,
  input  logic [fda_pkg::INT_W-1:0]     int_part_i,
  input  logic [fda_pkg::FRAC_W-1:0]    frac_part_i,
  input  logic                          cfg_we_i,
  input  logic [fda_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fda_pkg::CHAR_W-1:0]    char_code_o,
  output logic                          last_char_o
);

  localparam int unsigned INT_W  = fda_pkg::INT_W;
  localparam int unsigned DIG_W  = fda_pkg::DIG_W;
  localparam int unsigned PROD_W = fda_pkg::INT_W + fda_pkg::RECIP_W;
  localparam int unsigned Q_W    = PROD_W - fda_pkg::RECIP_SHIFT;
  localparam int unsigned F10_W  = FRAC_BITS + 4;
  localparam logic [fda_pkg::CFG_W-1:0] MaxK = fda_pkg::CFG_W'(MAX_FRAC_DIGITS);

  logic [fda_pkg::CFG_W-1:0] frac_digits_q;
  logic [fda_pkg::CFG_W-1:0] k_q, k_sat;
  logic [fda_pkg::CFG_W-1:0] fcnt_q, fcnt_d;
  logic [fda_pkg::ICNT_W-1:0] icnt_q, icnt_d;
  logic [INT_W-1:0] x_q, x_d;
  logic [FRAC_BITS-1:0] f_q, f_d;
  logic [fda_pkg::INT_DIGITS-1:0][DIG_W-1:0] dig_q, dig_d;
  logic out_valid_q, out_valid_d;
  logic [fda_pkg::CHAR_W-1:0] char_q, char_d;
  logic last_q, last_d;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0] quot;
  logic [INT_W-1:0] rem_full;
  logic [F10_W-1:0] f10;
  logic [FRAC_BITS+fda_pkg::FRAC_W-1:0] frac_ext;
  logic slot_free;

  assign k_sat    = (frac_digits_q > MaxK) ? MaxK : frac_digits_q;
  assign frac_ext = {{FRAC_BITS{1'b0}}, frac_part_i};

  // One division by ten per cycle on the integer part.
  assign prod     = {{fda_pkg::RECIP_W{1'b0}}, x_q} * {{INT_W{1'b0}}, fda_pkg::RECIP_TEN};
  assign quot     = prod[PROD_W-1:fda_pkg::RECIP_SHIFT];
  assign rem_full = x_q - (INT_W'(quot) << 3) - (INT_W'(quot) << 1);

  // One fraction digit per cycle while output has room: carry out of fraction*10.
  assign f10 = {1'b0, f_q, 3'b000} + {3'b000, f_q, 1'b0};

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    x_d    = x_q;
    f_d    = f_q;
    icnt_d = icnt_q;
    fcnt_d = fcnt_q;
    dig_d  = dig_q;
    if (cmd_i.load) begin
      x_d    = int_part_i;
      f_d    = frac_ext[FRAC_BITS-1:0];
      icnt_d = '0;
      fcnt_d = k_sat;
    end
    if (cmd_i.conv) begin
      x_d    = INT_W'(quot);
      dig_d  = {dig_q[fda_pkg::INT_DIGITS-2:0], rem_full[DIG_W-1:0]};
      icnt_d = icnt_q + 1'b1;
    end
    if (cmd_i.pop_int) begin
      dig_d  = {{DIG_W{1'b0}}, dig_q[fda_pkg::INT_DIGITS-1:1]};
      icnt_d = icnt_q - 1'b1;
    end
    if (cmd_i.emit_frac) begin
      f_d    = f10[FRAC_BITS-1:0];
      fcnt_d = fcnt_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.pop_int) begin
      out_valid_d = 1'b1;
      char_d      = fda_pkg::CHAR_ZERO + {2'b00, dig_q[0]};
      last_d      = (icnt_q == fda_pkg::ICNT_W'(1)) && (k_q == '0);
    end else if (cmd_i.emit_point) begin
      out_valid_d = 1'b1;
      char_d      = fda_pkg::CHAR_POINT;
      last_d      = 1'b0;
    end else if (cmd_i.emit_frac) begin
      out_valid_d = 1'b1;
      char_d      = fda_pkg::CHAR_ZERO + {2'b00, f10[F10_W-1:FRAC_BITS]};
      last_d      = (fcnt_q == fda_pkg::CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= fda_pkg::FRAC_DIGITS_RST;
      out_valid_q   <= 1'b0;
      icnt_q        <= '0;
      fcnt_q        <= '0;
      k_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        frac_digits_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        k_q <= k_sat;
      end
      out_valid_q <= out_valid_d;
      icnt_q      <= icnt_d;
      fcnt_q      <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    f_q    <= f_d;
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign sts_o.q_zero    = (quot == '0);
  assign sts_o.icnt_one  = (icnt_q == fda_pkg::ICNT_W'(1));
  assign sts_o.fcnt_one  = (fcnt_q == fda_pkg::CFG_W'(1));
  assign sts_o.k_zero    = (k_q == '0);
  assign sts_o.slot_free = slot_free;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // The digit stack never holds more than five integer digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.conv |-> (icnt_q < fda_pkg::ICNT_W'(fda_pkg::INT_DIGITS)))
    else $error("integer digit stack overflow");

  // Every character shown is a decimal digit or the point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((char_q == fda_pkg::CHAR_POINT) ||
                     ((char_q >= fda_pkg::CHAR_ZERO) && (char_q <= fda_pkg::CHAR_NINE))))
    else $error("character code out of range");

  // The point is never the last character of a number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_point |=> !last_q)
    else $error("point flagged as last character");

endmodule

// ----- rtl/fixed_to_decimal_ascii_core.sv -----
// Fixed-point to decimal text converter. Each input item carries a value with a
// 15-bit unsigned integer part and a fraction in units of 2^-FRAC_BITS (only the
// low FRAC_BITS bits of the fraction field count). The block answers with one
// output item per ASCII character, most significant first: the integer digits
// without leading zeros (a zero integer part gives a single '0'), then, when the
// frac_digits register is not zero, a '.' and exactly that many fraction digits,
// which are the fraction truncated (never rounded) to that many places. The
// final character of each number has tlast set. The frac_digits register resets
// to 2 and saturates at MAX_FRAC_DIGITS; it is written through the cfg channel
// and should only be changed while no number is in flight. Timing: after an
// item is taken, the integer part is broken into digits by one divide-by-ten
// per cycle, one per integer digit, then characters leave at one per cycle
// while the output side keeps tready high. One number is converted at a
// time; the next item can be taken at the clock edge after the last character
// of the previous one has been loaded into the output register.
module fixed_to_decimal_ascii_core #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned MAX_FRAC_DIGITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream. tdata bits, lowest first: int_part [14:0], frac_part [30:15],
  // zero pad [31].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fda_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Output stream. tdata bits, lowest first: char_code [5:0], zero pad [7:6].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fda_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  // Configuration: writes the frac_digits register.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fda_pkg::CFG_W-1:0]         cfg_data_i
);

  fda_pkg::cmd_t cmd;
  fda_pkg::sts_t sts;
  logic [fda_pkg::CHAR_W-1:0] char_code;
  logic in_ready;

  // The register can always take a write.
  assign cfg_ready_o = 1'b1;

  fda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fda_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .int_part_i  (s_axis_tdata[fda_pkg::INT_W-1:0]),
    .frac_part_i (s_axis_tdata[fda_pkg::INT_W+fda_pkg::FRAC_W-1:fda_pkg::INT_W]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .char_code_o (char_code),
    .last_char_o (m_axis_tlast)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = {{(fda_pkg::OUT_DATA_W - fda_pkg::CHAR_W){1'b0}}, char_code};

endmodule
